FILE: src/ntab_pkg.sv
package ntab_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned CountW = $clog2(TableDepth + 1);
  localparam int unsigned IdW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned PeriodW = 12;
  localparam int unsigned SpeedW = 12;
  localparam int unsigned FactorW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QuotW = 24;

  localparam logic [CfgIdxW-1:0] CfgMaxLife = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPeriodMode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSafetyFactor = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFixedPeriod = 2'd3;

  localparam logic [15:0] SpeedScale = 16'd57600;
  localparam logic [PeriodW-1:0] PeriodMin = 12'd100;
  localparam logic [PeriodW-1:0] PeriodMax = 12'd3000;
  localparam logic [CountW-1:0] CrowdLimit = 7'd50;
  localparam logic [PeriodW-1:0] CrowdPeriod = 12'd200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_DIV,
    ST_DONE
  } ntab_state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic sweep_step;
    logic div_start;
    logic div_step;
    logic finish;
  } ntab_cmd_t;

  typedef struct packed {
    logic mode;
    logic scan_last;
    logic found;
    logic div_last;
  } ntab_stat_t;

endpackage

FILE: src/ntab_ctrl.sv
module ntab_ctrl
  import ntab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  ntab_stat_t stat,
  output ntab_cmd_t  cmd
);

  ntab_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.mode) state_nxt = ST_SWEEP;
        else if (stat.found || stat.scan_last) state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        if (stat.scan_last) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        if (stat.mode) cmd.sweep_step = 1'b1;
        else cmd.scan_step = 1'b1;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.div_start = stat.scan_last;
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_DONE: cmd.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: src/ntab_dp.sv
module ntab_dp
  import ntab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ntab_cmd_t            cmd,
  output ntab_stat_t           stat,
  input  logic                 in_mode,
  input  logic [IdW-1:0]       in_station_id,
  input  logic [TimeW-1:0]     in_now_time,
  input  logic [SpeedW-1:0]    in_speed_q4,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic                 out_allocated,
  output logic                 out_table_full,
  output logic [SlotW-1:0]     out_slot_index,
  output logic [CountW-1:0]    out_neighbour_count,
  output logic [CountW-1:0]    out_evicted_count,
  output logic [PeriodW-1:0]   out_period_ms,
  output logic                 out_period_changed
);

  logic [TimeW-1:0]   max_life_r;
  logic               period_mode_r;
  logic [FactorW-1:0] safety_factor_r;
  logic [PeriodW-1:0] fixed_period_r;

  logic [TableDepth-1:0] valid_r;
  logic [IdW-1:0]        id_mem [TableDepth];
  logic [TimeW-1:0]      time_mem [TableDepth];

  logic                mode_r;
  logic [IdW-1:0]      id_r;
  logic [TimeW-1:0]    now_r;
  logic [SpeedW-1:0]   speed_r;
  logic [SlotW-1:0]    ptr_r;
  logic                found_r;
  logic                free_ok_r;
  logic [SlotW-1:0]    free_r;
  logic [CountW-1:0]   live_r;
  logic [CountW-1:0]   evict_r;
  logic [PeriodW-1:0]  last_period_r;
  logic [QuotW-1:0]    quo_r;
  logic [SpeedW:0]     rem_r;
  logic [4:0]          div_cnt_r;
  logic [IdW-1:0]      rd_id_r;
  logic [TimeW-1:0]    rd_time_r;

  logic                advance;
  logic [SlotW-1:0]    rd_addr;
  logic                cur_valid;
  logic                match;
  logic                aged;
  logic [TimeW-1:0]    age;
  logic [SpeedW+1:0]   trial;
  logic [QuotW-1:0]    dividend;
  logic [PeriodW-1:0]  period;
  logic [PeriodW-1:0]  p_trunc;
  logic [PeriodW+15:0] p_mul;
  logic [PeriodW-1:0]  p_tens;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_life_r      <= 32'd5000;
      period_mode_r   <= 1'b0;
      safety_factor_r <= 8'd5;
      fixed_period_r  <= 12'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgMaxLife:      max_life_r <= cfg_data;
        CfgPeriodMode:   period_mode_r <= cfg_data[0];
        CfgSafetyFactor: safety_factor_r <= cfg_data[FactorW-1:0];
        CfgFixedPeriod:  fixed_period_r <= cfg_data[PeriodW-1:0];
        default:         max_life_r <= max_life_r;
      endcase
    end
  end

  assign advance = cmd.sweep_step || (cmd.scan_step && !match);
  assign rd_addr = cmd.load ? '0 : (advance ? ptr_r + 1'b1 : ptr_r);
  assign cur_valid = valid_r[ptr_r];
  assign match = cur_valid && (rd_id_r == id_r);
  assign age = now_r - rd_time_r;
  assign aged = cur_valid && (age >= max_life_r);
  assign dividend = QuotW'(safety_factor_r) * QuotW'(SpeedScale);
  assign trial = {rem_r, dividend[QuotW-1-div_cnt_r]} - {2'b00, speed_r};

  assign stat.mode = mode_r;
  assign stat.scan_last = (ptr_r == SlotW'(TableDepth - 1));
  assign stat.found = match;
  assign stat.div_last = (div_cnt_r == 5'(QuotW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      id_r    <= in_station_id;
      now_r   <= in_now_time;
      speed_r <= in_speed_q4;
      ptr_r   <= '0;
      found_r <= 1'b0;
      free_ok_r <= 1'b0;
      free_r  <= '0;
      evict_r <= '0;
    end else if (cmd.scan_step) begin
      if (match) begin
        found_r <= 1'b1;
      end else begin
        if (!cur_valid && !free_ok_r) begin
          free_ok_r <= 1'b1;
          free_r <= ptr_r;
        end
        ptr_r <= ptr_r + 1'b1;
      end
    end else if (cmd.sweep_step) begin
      if (aged) evict_r <= evict_r + 1'b1;
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.div_start) begin
      quo_r <= '0;
      rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!trial[SpeedW+1]) begin
        rem_r <= trial[SpeedW:0];
        quo_r <= {quo_r[QuotW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[SpeedW-1:0], dividend[QuotW-1-div_cnt_r]};
        quo_r <= {quo_r[QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !mode_r && !found_r && free_ok_r) begin
      id_mem[free_r] <= id_r;
    end
    if (cmd.finish && !mode_r && (found_r || free_ok_r)) begin
      time_mem[found_r ? ptr_r : free_r] <= now_r;
    end
    rd_id_r <= id_mem[rd_addr];
    rd_time_r <= time_mem[rd_addr];
  end

  assign p_trunc = quo_r[PeriodW-1:0];
  assign p_mul = (PeriodW+16)'(p_trunc) * (PeriodW+16)'(16'd6554);
  assign p_tens = p_mul[PeriodW+15:16] * PeriodW'(10);

  always_comb begin
    if (!period_mode_r) begin
      if (speed_r == '0) period = PeriodMax;
      else if (quo_r > QuotW'(PeriodMax)) period = PeriodMax;
      else if (p_trunc < PeriodMin) period = PeriodMin;
      else period = p_tens;
    end else if (live_r > CrowdLimit) begin
      period = CrowdPeriod;
    end else begin
      period = fixed_period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      live_r <= '0;
      last_period_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.sweep_step && aged) begin
        valid_r[ptr_r] <= 1'b0;
        live_r <= live_r - 1'b1;
      end
      if (cmd.finish) begin
        if (mode_r) begin
          last_period_r <= period;
        end else if (!found_r && free_ok_r) begin
          valid_r[free_r] <= 1'b1;
          live_r <= live_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit <= !mode_r && found_r;
      out_allocated <= !mode_r && !found_r && free_ok_r;
      out_table_full <= !mode_r && !found_r && !free_ok_r;
      out_slot_index <= mode_r ? '0 : (found_r ? ptr_r : (free_ok_r ? free_r : '0));
      out_neighbour_count <= (!mode_r && !found_r && free_ok_r) ? live_r + 1'b1 : live_r;
      out_evicted_count <= mode_r ? evict_r : '0;
      out_period_ms <= mode_r ? period : '0;
      out_period_changed <= mode_r && (period != last_period_r);
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CountW'(TableDepth)) else $error("live count overflow");
  a_outcome_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_period_changed && out_period_ms == '0 && out_evicted_count == '0
      |-> $countones({out_hit, out_allocated, out_table_full}) <= 1)
    else $error("lookup outcome not exclusive");
  a_live_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(live_r)) else $error("live count mismatch");
`endif

endmodule

FILE: src/neighbour_table_with_aging.sv
// Neighbour table of 64 stations with aging. Raise start while busy is low to
// issue a request; out_valid marks its single result for one cycle, and the
// receiver cannot stall it. A lookup scans slots one per cycle until a match
// or the last slot; a sweep walks all 64 slots, then a restoring divider gives
// the period. Configuration is to be written by the user through
// cfg_we/cfg_index/cfg_data while idle; the block does not enforce this.
module neighbour_table_with_aging
  import ntab_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [IdW-1:0]      in_station_id,
  input  logic [TimeW-1:0]    in_now_time,
  input  logic [SpeedW-1:0]   in_speed_q4,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output logic                out_valid,
  output logic                out_hit,
  output logic                out_allocated,
  output logic                out_table_full,
  output logic [SlotW-1:0]    out_slot_index,
  output logic [CountW-1:0]   out_neighbour_count,
  output logic [CountW-1:0]   out_evicted_count,
  output logic [PeriodW-1:0]  out_period_ms,
  output logic                out_period_changed
);

  ntab_cmd_t  cmd;
  ntab_stat_t stat;

  ntab_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  ntab_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_mode(in_mode), .in_station_id(in_station_id), .in_now_time(in_now_time),
    .in_speed_q4(in_speed_q4), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_hit(out_hit),
    .out_allocated(out_allocated), .out_table_full(out_table_full),
    .out_slot_index(out_slot_index), .out_neighbour_count(out_neighbour_count),
    .out_evicted_count(out_evicted_count), .out_period_ms(out_period_ms),
    .out_period_changed(out_period_changed)
  );

endmodule
